/* rtl/core/fcbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbs_pkg
// Shared constants, widths and codes of the fake-capacity block store.
// ----------------------------------------------------------------------------
package fcbs_pkg;

   localparam int BLOCK_WORDS       = 128;
   localparam int REAL_BLOCKS       = 1024;
   localparam int CACHE_SLOTS_MAX   = 16;
   localparam int BLOCK_NUMBER_BITS = 32;

   // field widths
   localparam int BLK_W    = 32;
   localparam int WORD_W   = 7;
   localparam int DATA_W   = 32;
   localparam int REGION_W = 2;

   // configuration widths
   localparam int REAL_SIZE_W = 11;
   localparam int WRAP_W      = 6;
   localparam int ORDER_W     = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 11;

   // derived storage geometry
   localparam int BW_W         = $clog2(BLOCK_WORDS);
   localparam int RB_W         = $clog2(REAL_BLOCKS);
   localparam int SLOT_W       = (CACHE_SLOTS_MAX > 1) ? $clog2(CACHE_SLOTS_MAX) : 1;
   localparam int REAL_WORDS   = REAL_BLOCKS * BLOCK_WORDS;
   localparam int CACHE_WORDS  = CACHE_SLOTS_MAX * BLOCK_WORDS;
   localparam int REAL_ADDR_W  = $clog2(REAL_WORDS);
   localparam int CACHE_ADDR_W = $clog2(CACHE_WORDS);

   localparam logic [BLK_W-1:0] BLK_MASK = (BLOCK_NUMBER_BITS >= BLK_W) ? '1 :
      BLK_W'((64'd1 << BLOCK_NUMBER_BITS) - 64'd1);
   localparam logic [REAL_SIZE_W-1:0] REAL_SIZE_LIM = REAL_SIZE_W'(REAL_BLOCKS);

   // configuration reset values
   localparam logic [REAL_SIZE_W-1:0] REAL_SIZE_RST = 11'd1024;
   localparam logic [WRAP_W-1:0]      WRAP_RST      = 6'd32;

   // stream packing
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [REGION_W-1:0] {
      REGION_REAL  = 2'd0,
      REGION_CACHE = 2'd1,
      REGION_NONE  = 2'd2
   } region_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REAL_SIZE    = 3'd0,
      CSR_WRAP_BITS    = 3'd1,
      CSR_CACHE_ENABLE = 3'd2,
      CSR_CACHE_ORDER  = 3'd3,
      CSR_STRICT_CACHE = 3'd4
   } csr_idx_type;

endpackage

/* rtl/core/fcbs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbs_ram
// Generic single-port RAM, write or registered read once per cycle.
// ----------------------------------------------------------------------------
module fcbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/fake_capacity_block_store_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fake_capacity_block_store_core
// Counterfeit-capacity storage emulator, one word read or write per item.
// ----------------------------------------------------------------------------
// req channel carries one word access (read or write of one word of a block);
// rsp channel returns one result per access, in order: read data (zero on
// writes and unbacked accesses) and the region that served it.
// csr port writes the five settings; the user must write them only while
// the block is idle, and the block itself does not enforce it.
// path: a req transfer loads the input register, then the item passes the
// memory access with registered read and the output register (rsp_tvalid).
// throughput: one item per cycle while rsp_tready is high and no clearing
// pass runs, set by the single port of each memory.
// reset: settings return to defaults and a clearing pass writes zero to every
// word of the real store (and the overflow cache alongside it), one word per
// cycle, over all REAL_BLOCKS * BLOCK_WORDS = 131072 words; req_tready stays
// low until it is done.
// stall: while rsp_tready is low the result holds in the output register; the
// pipeline behind it keeps filling and req_tready drops once all stages hold.
// ----------------------------------------------------------------------------
module fake_capacity_block_store_core
   import fcbs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // action, block_number, word_index, write_data
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // read_data, region, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic [REAL_SIZE_W-1:0] real_size_ff;
   logic [WRAP_W-1:0]      wrap_bits_ff;
   logic                   cache_en_ff;
   logic [ORDER_W-1:0]     slot_order_ff;
   logic                   strict_ff;

   // clearing pass
   logic                   clr_ff, clr_in;
   logic [REAL_ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;

   // input stage
   logic              s0_valid_ff, s0_valid_in;
   logic              s0_wr_ff;
   logic [BLK_W-1:0]  s0_blk_ff;
   logic [WORD_W-1:0] s0_word_ff;
   logic [DATA_W-1:0] s0_data_ff;

   // memory stage
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_wr_ff;
   region_type s1_region_ff;

   // output stage
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   region_type          rsp_region_ff;

   logic [BLK_W-1:0] tag_ff [CACHE_SLOTS_MAX];

   logic req_xfer, out_ld, s1_adv, issue;
   logic [BLK_W-1:0] blk, wrap_mask, wrapped;
   logic [REAL_SIZE_W-1:0] real_n;
   logic [SLOT_W-1:0] slot_mask, slot;
   logic in_range, is_real, is_ovf, tag_ok, cache_hit;
   region_type region;
   logic real_en, real_we, cache_en, cache_we, tag_we;
   logic [REAL_ADDR_W-1:0]  real_addr;
   logic [CACHE_ADDR_W-1:0] cache_addr;
   logic [DATA_W-1:0] real_wdata, cache_wdata, real_rd, cache_rd;

   // handshake and stage advance
   assign out_ld      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign s1_adv      = !s1_valid_ff || out_ld;
   assign issue       = s0_valid_ff && s1_adv && !clr_ff;
   assign req_tready  = !clr_ff && (!s0_valid_ff || issue);
   assign req_xfer    = req_tvalid && req_tready;

   // address decode
   always_comb begin
      blk       = s0_blk_ff & BLK_MASK;
      wrap_mask = ~({BLK_W{1'b1}} << wrap_bits_ff);
      wrapped   = blk & wrap_mask;
      real_n    = (real_size_ff < REAL_SIZE_LIM) ? real_size_ff : REAL_SIZE_LIM;
      slot_mask = ~({SLOT_W{1'b1}} << slot_order_ff);
      slot      = blk[SLOT_W-1:0] & slot_mask;
      in_range  = {1'b0, s0_word_ff} < (WORD_W+1)'(BLOCK_WORDS);
      is_real   = in_range && (wrapped < BLK_W'(real_n));
      is_ovf    = in_range && !is_real && cache_en_ff;
      tag_ok    = !strict_ff || (tag_ff[slot] == blk);
      cache_hit = is_ovf && (s0_wr_ff || tag_ok);
      if (is_real) begin
         region = REGION_REAL;
      end else if (cache_hit) begin
         region = REGION_CACHE;
      end else begin
         region = REGION_NONE;
      end
   end

   // memory ports, shared with the clearing pass
   always_comb begin
      tag_we = issue && is_ovf && s0_wr_ff && strict_ff;
      if (clr_ff) begin
         real_en     = 1'b1;
         real_we     = 1'b1;
         real_addr   = clr_cnt_ff;
         real_wdata  = '0;
         cache_en    = 1'b1;
         cache_we    = 1'b1;
         cache_addr  = clr_cnt_ff[CACHE_ADDR_W-1:0];
         cache_wdata = '0;
      end else begin
         real_en     = issue && is_real;
         real_we     = s0_wr_ff;
         real_addr   = {wrapped[RB_W-1:0], s0_word_ff[BW_W-1:0]};
         real_wdata  = s0_data_ff;
         cache_en    = issue && is_ovf;
         cache_we    = s0_wr_ff;
         cache_addr  = {slot, s0_word_ff[BW_W-1:0]};
         cache_wdata = s0_data_ff;
      end
   end

   fcbs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (REAL_WORDS)
   ) u_real_ram (
      .clock (clock),
      .en    (real_en),
      .we    (real_we),
      .addr  (real_addr),
      .wdata (real_wdata),
      .rdata (real_rd)
   );

   fcbs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CACHE_WORDS)
   ) u_cache_ram (
      .clock (clock),
      .en    (cache_en),
      .we    (cache_we),
      .addr  (cache_addr),
      .wdata (cache_wdata),
      .rdata (cache_rd)
   );

   // next-state logic
   always_comb begin
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == REAL_ADDR_W'(REAL_WORDS - 1)) begin
            clr_in = 1'b0;
         end
      end

      s0_valid_in = req_xfer ? 1'b1 : (issue ? 1'b0 : s0_valid_ff);
      s1_valid_in = issue ? 1'b1 : (out_ld ? 1'b0 : s1_valid_ff);
      rsp_valid_in = out_ld ? 1'b1 : ((rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff);

      if (!s1_wr_ff && s1_region_ff == REGION_REAL) begin
         rsp_data_in = real_rd;
      end else if (!s1_wr_ff && s1_region_ff == REGION_CACHE) begin
         rsp_data_in = cache_rd;
      end else begin
         rsp_data_in = '0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         real_size_ff   <= REAL_SIZE_RST;
         wrap_bits_ff   <= WRAP_RST;
         cache_en_ff    <= 1'b0;
         slot_order_ff  <= '0;
         strict_ff      <= 1'b0;
         clr_ff         <= 1'b1;
         clr_cnt_ff     <= '0;
         s0_valid_ff    <= 1'b0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < CACHE_SLOTS_MAX; i++) begin
            tag_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_REAL_SIZE:    real_size_ff   <= csr_wdata;
               CSR_WRAP_BITS:    wrap_bits_ff   <= csr_wdata[WRAP_W-1:0];
               CSR_CACHE_ENABLE: cache_en_ff    <= csr_wdata[0];
               CSR_CACHE_ORDER:  slot_order_ff  <= csr_wdata[ORDER_W-1:0];
               CSR_STRICT_CACHE: strict_ff      <= csr_wdata[0];
               default: ;
            endcase
         end
         clr_ff       <= clr_in;
         clr_cnt_ff   <= clr_cnt_in;
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (tag_we) begin
            tag_ff[slot] <= blk;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s0_wr_ff   <= req_tdata[0];
         s0_blk_ff  <= req_tdata[BLK_W:1];
         s0_word_ff <= req_tdata[BLK_W+WORD_W:BLK_W+1];
         s0_data_ff <= req_tdata[BLK_W+WORD_W+DATA_W:BLK_W+WORD_W+1];
      end
      if (issue) begin
         s1_wr_ff     <= s0_wr_ff;
         s1_region_ff <= region;
      end
      if (out_ld) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_region_ff <= s1_region_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-DATA_W-REGION_W)'(0), rsp_region_ff, rsp_data_ff};

`ifndef SYNTHESIS
   a_region_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[33:32] != 2'd3))
      else $error("undefined region code on rsp");

   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      (out_ld && s1_wr_ff) |=> (rsp_tdata[DATA_W-1:0] == '0))
      else $error("write transfer returned nonzero data");

   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      $fell(clr_ff) |-> ($past(clr_cnt_ff) == REAL_ADDR_W'(REAL_WORDS - 1)))
      else $error("clearing pass ended early");

   a_no_issue_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> (!s0_valid_ff && !s1_valid_ff))
      else $error("item in flight during clearing pass");
`endif

endmodule
